/* sv/cbq_pkg.sv */
package cbq_pkg;

    localparam int COEF_W = 32;
    localparam int COEF_FRAC = 28;
    localparam int DLY_W = 40;
    localparam int NCOEF = 5;
    localparam int PROD_W = COEF_W + DLY_W;

    typedef logic signed [DLY_W-1:0] dly_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef enum logic [0:0] {
        REQ_LOAD   = 1'b0,
        REQ_SAMPLE = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        CS_B0 = 3'd0,
        CS_B1 = 3'd1,
        CS_B2 = 3'd2,
        CS_A1 = 3'd3,
        CS_A2 = 3'd4
    } coef_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD,
        ST_P0,
        ST_P1,
        ST_Y,
        ST_P3,
        ST_P4,
        ST_WR,
        ST_OUT
    } state_t;

    // Round a coefficient product to nearest (ties up) after dropping COEF_FRAC bits.
    function automatic prod_t rnd(input prod_t p);
        prod_t t;
        t = p + (prod_t'(1) <<< (COEF_FRAC - 1));
        return t >>> COEF_FRAC;
    endfunction

    // Saturate a wide value to the signed delay range.
    function automatic dly_t sat40(input prod_t v);
        prod_t mx;
        prod_t mn;
        mx = (prod_t'(1) <<< (DLY_W - 1)) - prod_t'(1);
        mn = -mx - prod_t'(1);
        if (v > mx) return dly_t'(mx);
        if (v < mn) return dly_t'(mn);
        return dly_t'(v);
    endfunction

endpackage

/* sv/cascaded_biquad_filter.sv */
// Multichannel cascade of second-order IIR sections in transposed direct
// form II. A load item (req_type 0) writes one coefficient; a sample item
// (req_type 1) runs its channel's sample through all SECTIONS sections and
// returns one result; loads and samples for absent channels give none.
// Coefficients and delays live in synchronous memories with one write and
// one read port. One shared multiplier, built from two 32x20 partial
// products, forms one of the five products of a section per cycle. A
// section runs memory read, five products and delay write-back, in that
// order. A sample's result enters the output register after its last
// section is written back; no new item is taken before then. A load is
// written as it is accepted, and the block stays ready. After reset a
// clearing pass over all CHANNELS*SECTIONS rows zeroes the delay memory,
// during which no item is accepted. A finished result waits in the output
// register while the next item is taken; a second finished result holds
// the block until the first is taken.
module cascaded_biquad_filter #(
    parameter int CHANNELS = 8,
    parameter int SECTIONS = 5,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_req_type,
    input  logic [2:0]             s_channel,
    input  logic [2:0]             s_stage,
    input  logic [2:0]             s_coef_sel,
    input  logic signed [31:0]     s_coef_value,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  logic                   s_block_end,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_out_channel,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    output logic                   m_out_block_end
);
    import cbq_pkg::*;

    localparam int ROWS = CHANNELS * SECTIONS;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int VL_W = 20;

    // One row per (channel, section): five coefficients, two delays.
    coef_t coef_mem [ROWS][NCOEF];
    dly_t  dly_mem  [ROWS][2];

    state_t state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic [SW-1:0] sec_reg, sec_next;
    logic [2:0] ch_reg, ch_next;
    logic be_reg, be_next;
    dly_t x_reg, x_next, y_reg, y_next;
    prod_t acc0_reg, acc0_next, acc1_reg, acc1_next;
    prod_t prod_reg, prod_next;
    coef_t c_rd [NCOEF];
    dly_t d_rd [2];
    logic out_v_reg, out_v_next;
    logic [2:0] out_ch_reg, out_ch_next;
    logic signed [SAMPLE_BITS-1:0] out_s_reg, out_s_next;
    logic out_be_reg, out_be_next;

    logic accept;
    logic load_ok;
    logic [RW-1:0] load_row;
    logic dly_we;
    dly_t wr_d0, wr_d1;
    coef_t mul_c;
    dly_t mul_v;
    logic signed [DLY_W-VL_W-1:0] mul_vh;
    logic signed [VL_W:0] mul_vl;
    logic signed [COEF_W+DLY_W-VL_W-1:0] part_hi;
    logic signed [COEF_W+VL_W:0] part_lo;
    prod_t smx;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept = s_valid && s_ready;
    assign load_ok = ({29'd0, s_channel} < CHANNELS) && ({29'd0, s_stage} < SECTIONS)
                     && ({29'd0, s_coef_sel} < NCOEF);
    assign load_row = RW'(32'(s_channel) * SECTIONS + 32'(s_stage));

    always_ff @(posedge aclk) begin
        if (accept && s_req_type == REQ_LOAD && load_ok) begin
            coef_mem[load_row][s_coef_sel] <= s_coef_value;
        end
        c_rd <= coef_mem[row_reg];
        d_rd <= dly_mem[row_reg];
        if (dly_we) begin
            dly_mem[row_reg][0] <= wr_d0;
            dly_mem[row_reg][1] <= wr_d1;
        end
    end

    // Multiplier operand select.
    always_comb begin
        mul_c = c_rd[CS_B0];
        mul_v = x_reg;
        case (state_reg)
            ST_P0: begin mul_c = c_rd[CS_B0]; mul_v = x_reg; end
            ST_P1: begin mul_c = c_rd[CS_B1]; mul_v = x_reg; end
            ST_Y:  begin mul_c = c_rd[CS_B2]; mul_v = x_reg; end
            ST_P3: begin mul_c = c_rd[CS_A1]; mul_v = y_reg; end
            ST_P4: begin mul_c = c_rd[CS_A2]; mul_v = y_reg; end
            default: ;
        endcase
    end

    // Split the 40-bit operand: signed upper part, unsigned lower part.
    assign mul_vh = mul_v[DLY_W-1:VL_W];
    assign mul_vl = {1'b0, mul_v[VL_W-1:0]};
    assign part_hi = mul_c * mul_vh;
    assign part_lo = mul_c * mul_vl;

    always_comb begin
        smx = (prod_t'(1) <<< (SAMPLE_BITS - 1)) - prod_t'(1);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_req_type == REQ_SAMPLE
                    && {29'd0, s_channel} < CHANNELS) state_next = ST_RD;
            end
            ST_CLEAR: if (row_reg == RW'(ROWS - 1)) state_next = ST_IDLE;
            ST_RD:  state_next = ST_P0;
            ST_P0:  state_next = ST_P1;
            ST_P1:  state_next = ST_Y;
            ST_Y:   state_next = ST_P3;
            ST_P3:  state_next = ST_P4;
            ST_P4:  state_next = ST_WR;
            ST_WR:  state_next = (sec_reg == SW'(SECTIONS - 1)) ? ST_OUT : ST_RD;
            ST_OUT: if (!out_v_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        row_next = row_reg;
        sec_next = sec_reg;
        ch_next = ch_reg;
        be_next = be_reg;
        x_next = x_reg;
        y_next = y_reg;
        acc0_next = acc0_reg;
        acc1_next = acc1_reg;
        prod_next = (prod_t'(part_hi) <<< VL_W) + prod_t'(part_lo);
        out_v_next = out_v_reg && !m_ready;
        out_ch_next = out_ch_reg;
        out_s_next = out_s_reg;
        out_be_next = out_be_reg;
        dly_we = 1'b0;
        wr_d0 = '0;
        wr_d1 = '0;
        case (state_reg)
            ST_IDLE: begin
                row_next = RW'(32'(s_channel) * SECTIONS);
                sec_next = '0;
                ch_next = s_channel;
                be_next = s_block_end;
                x_next = dly_t'(s_sample_in);
            end
            ST_CLEAR: begin
                dly_we = 1'b1;
                row_next = row_reg + RW'(1);
            end
            // prod holds b0*x entering ST_P1, b1*x entering ST_Y, etc.
            ST_P1: begin
                y_next = sat40(rnd(prod_reg) + prod_t'(d_rd[0]));
            end
            // keep the partial sums wide; saturate only at write-back
            ST_Y: begin
                acc0_next = rnd(prod_reg) + prod_t'(d_rd[1]);
            end
            ST_P3: begin
                acc1_next = rnd(prod_reg);
            end
            ST_P4: begin
                acc0_next = acc0_reg - rnd(prod_reg);
            end
            ST_WR: begin
                dly_we = 1'b1;
                wr_d0 = sat40(acc0_reg);
                wr_d1 = sat40(acc1_reg - rnd(prod_reg));
                x_next = y_reg;
                row_next = row_reg + RW'(1);
                sec_next = sec_reg + SW'(1);
            end
            ST_OUT: begin
                if (!out_v_reg || m_ready) begin
                    out_v_next = 1'b1;
                    out_ch_next = ch_reg;
                    out_be_next = be_reg;
                    if (prod_t'(x_reg) > smx) out_s_next = SAMPLE_BITS'(smx);
                    else if (prod_t'(x_reg) < -smx - prod_t'(1))
                        out_s_next = SAMPLE_BITS'(-smx - prod_t'(1));
                    else out_s_next = SAMPLE_BITS'(x_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            row_reg <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg <= row_next;
            out_v_reg <= out_v_next;
        end
        sec_reg <= sec_next;
        ch_reg <= ch_next;
        be_reg <= be_next;
        x_reg <= x_next;
        y_reg <= y_next;
        acc0_reg <= acc0_next;
        acc1_reg <= acc1_next;
        prod_reg <= prod_next;
        out_ch_reg <= out_ch_next;
        out_s_reg <= out_s_next;
        out_be_reg <= out_be_next;
    end

    assign m_valid = out_v_reg;
    assign m_out_channel = out_ch_reg;
    assign m_sample_out = out_s_reg;
    assign m_out_block_end = out_be_reg;

endmodule
